/* sv/bba_pkg.sv */
`default_nettype none

package bba_pkg;

   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam logic MODE_ALLOC  = 1'b0;
   localparam logic MODE_RETURN = 1'b1;

   localparam logic [1:0] ST_GRANTED  = 2'd0;
   localparam logic [1:0] ST_NONE     = 2'd1;
   localparam logic [1:0] ST_RETURNED = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [9:0] block_number;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] granted_block;
   } rsp_type;

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] bits);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

/* sv/bitmap_block_allocator.sv */
`default_nettype none

// Channel   Direction  Handshake             Word
// req       in         req_valid/req_stall   req_data (mode, block_number)
// rsp       out        rsp_valid/rsp_stall   rsp_data (status, granted_block)
//
// A return passes S_RET_RD, S_RET_WR, S_DONE to the result register, an allocation S_GNT_RD,
// S_GNT_WR, S_DONE plus S_SCAN_RD, S_SCAN_CHK per further 32-bit bitmap word scanned for
// the next free block; an out-of-range return or an allocation with no block left goes
// straight to S_DONE. A merge reads, then writes, each bitmap word in turn; the single
// read port sets this. After reset a pass frees all blocks and clears the returned map.
// A finished result waits in the output register while the next word is accepted.
module bitmap_block_allocator #(
   parameter int BLOCK_COUNT = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bba_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bba_pkg::rsp_type       rsp_data
);

   import bba_pkg::*;

   localparam int NUM_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
   localparam int PTR_W     = $clog2(BLOCK_COUNT + 1);
   localparam int LAST_BITS = BLOCK_COUNT - (NUM_WORDS - 1) * WORD_W;

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);
   localparam logic [PTR_W-1:0]  PTR_END   = PTR_W'(BLOCK_COUNT);
   localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RET_RD   = 4'd2;
   localparam logic [3:0] S_RET_WR   = 4'd3;
   localparam logic [3:0] S_MERGE_RD = 4'd4;
   localparam logic [3:0] S_MERGE_WR = 4'd5;
   localparam logic [3:0] S_GNT_RD   = 4'd6;
   localparam logic [3:0] S_GNT_WR   = 4'd7;
   localparam logic [3:0] S_SCAN_RD  = 4'd8;
   localparam logic [3:0] S_SCAN_CHK = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic              found_ff, found_in;
   logic              ret_any_ff, ret_any_in;
   logic              rsp_valid_ff, rsp_valid_in;
   req_type           req_ff, req_in;
   logic [1:0]        status_ff, status_in;
   logic [9:0]        grant_ff, grant_in;
   rsp_type           rsp_ff, rsp_in;

   logic              avail_we, ret_we;
   logic [WIDX_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] avail_wdata, ret_wdata, avail_rdata, ret_rdata;

   logic              req_take, out_free, ret_in_range;
   logic [WIDX_W-1:0] ptr_word, ret_word;
   logic [BIT_W-1:0]  ptr_bit;
   logic [WORD_W-1:0] merged, cleared, above;

   bba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_avail_ram (
      .clock   (clock),
      .wr_en   (avail_we),
      .wr_addr (wr_addr),
      .wr_data (avail_wdata),
      .rd_addr (rd_addr),
      .rd_data (avail_rdata)
   );

   bba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_ret_ram (
      .clock   (clock),
      .wr_en   (ret_we),
      .wr_addr (wr_addr),
      .wr_data (ret_wdata),
      .rd_addr (rd_addr),
      .rd_data (ret_rdata)
   );

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ptr_word     = WIDX_W'(ptr_ff >> BIT_W);
   assign ptr_bit      = BIT_W'(ptr_ff);
   assign ret_word     = WIDX_W'(req_ff.block_number >> BIT_W);
   assign ret_in_range = 32'(req_data.block_number) < 32'(BLOCK_COUNT);
   assign merged       = avail_rdata | ret_rdata;
   assign cleared      = avail_rdata & ~(WORD_W'(1) << ptr_bit);
   assign above        = cleared & (({WORD_W{1'b1}} << ptr_bit) << 1);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      word_in      = word_ff;
      found_in     = found_ff;
      ret_any_in   = ret_any_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      avail_we     = 1'b0;
      ret_we       = 1'b0;
      wr_addr      = word_ff;
      rd_addr      = word_ff;
      avail_wdata  = merged;
      ret_wdata    = '0;

      case (state_ff)
         S_INIT: begin
            avail_we    = 1'b1;
            ret_we      = 1'b1;
            avail_wdata = (word_ff == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};
            if (word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WIDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               if (req_data.mode == MODE_RETURN) begin
                  status_in = ST_RETURNED;
                  grant_in  = '0;
                  state_in  = ret_in_range ? S_RET_RD : S_DONE;
               end else if (ptr_ff < PTR_END) begin
                  state_in = S_GNT_RD;
               end else if (ret_any_ff) begin
                  word_in  = '0;
                  found_in = 1'b0;
                  state_in = S_MERGE_RD;
               end else begin
                  status_in = ST_NONE;
                  grant_in  = '0;
                  state_in  = S_DONE;
               end
            end
         end
         S_RET_RD: begin
            rd_addr  = ret_word;
            state_in = S_RET_WR;
         end
         S_RET_WR: begin
            wr_addr    = ret_word;
            ret_we     = 1'b1;
            ret_wdata  = ret_rdata | (WORD_W'(1) << req_ff.block_number[BIT_W-1:0]);
            ret_any_in = 1'b1;
            state_in   = S_DONE;
         end
         S_MERGE_RD: begin
            state_in = S_MERGE_WR;
         end
         S_MERGE_WR: begin
            avail_we = 1'b1;
            ret_we   = 1'b1;
            if (!found_ff && merged != '0) begin
               found_in = 1'b1;
               ptr_in   = PTR_W'({word_ff, lowest_bit(merged)});
            end
            if (word_ff == LAST_WORD) begin
               ret_any_in = 1'b0;
               if (found_ff || merged != '0) begin
                  state_in = S_GNT_RD;
               end else begin
                  ptr_in    = PTR_END;
                  status_in = ST_NONE;
                  grant_in  = '0;
                  state_in  = S_DONE;
               end
            end else begin
               word_in  = word_ff + WIDX_W'(1);
               state_in = S_MERGE_RD;
            end
         end
         S_GNT_RD: begin
            rd_addr  = ptr_word;
            state_in = S_GNT_WR;
         end
         S_GNT_WR: begin
            wr_addr     = ptr_word;
            avail_we    = 1'b1;
            avail_wdata = cleared;
            status_in   = ST_GRANTED;
            grant_in    = 10'(ptr_ff);
            if (above != '0) begin
               ptr_in   = PTR_W'({ptr_word, lowest_bit(above)});
               state_in = S_DONE;
            end else if (ptr_word == LAST_WORD) begin
               ptr_in   = PTR_END;
               state_in = S_DONE;
            end else begin
               word_in  = ptr_word + WIDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (avail_rdata != '0) begin
               ptr_in   = PTR_W'({word_ff, lowest_bit(avail_rdata)});
               state_in = S_DONE;
            end else if (word_ff == LAST_WORD) begin
               ptr_in   = PTR_END;
               state_in = S_DONE;
            end else begin
               word_in  = word_ff + WIDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.status        = status_ff;
               rsp_in.granted_block = grant_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         word_ff      <= '0;
         found_ff     <= 1'b0;
         ret_any_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         word_ff      <= word_in;
         found_ff     <= found_in;
         ret_any_ff   <= ret_any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
      rsp_ff    <= rsp_in;
   end

endmodule

`default_nettype wire

/* sv/bba_ram.sv */
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
